FILE: design/hlm_pkg.sv
// Shared types and codes of the heartbeat link monitor.
package hlm_pkg;

  // Input command codes
  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_REPLY    = 3'd1,
    CMD_DEADLINE = 3'd2,
    CMD_REPORT   = 3'd3,
    CMD_RX_ERROR = 3'd4
  } cmd_e;

  // Result event codes
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_SENT    = 2'd1,
    EV_REPLY   = 2'd2,
    EV_TIMEOUT = 2'd3
  } ev_e;

  // Configuration register indexes
  localparam logic CFG_FAIL_LIMIT    = 1'b0;
  localparam logic CFG_REAL_POWEROFF = 1'b1;

  localparam logic [7:0] FAIL_LIMIT_RST = 8'd3;

  typedef struct packed {
    logic [7:0] fail_limit;
    logic       real_poweroff;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [47:0] now_us;
    logic [15:0] probe_number;
    logic        send_ok;
    logic        action_ok;
  } item_t;

  typedef struct packed {
    ev_e         event_kind;
    logic [31:0] reply_lat;
    logic [7:0]  fail_streak;
    logic        shutdown_request;
    logic        halted;
    logic        exit_status;
    logic [31:0] total_count;
    logic [31:0] ok_count;
    logic [31:0] failed_count;
    logic [47:0] latency_total;
    logic [31:0] latency_low;
    logic [31:0] latency_high;
  } result_t;

endpackage

FILE: design/heartbeat_link_monitor.sv
// Heartbeat link monitor top level: stream ports, input and result registers, config.
//
// Usage: events enter on the s_axis channel (tuser carries the command code,
// tdata the time stamp, probe number and the two status flags). Every accepted
// request yields exactly one result on the m_axis channel: tuser is the event
// kind, tdata the streak, shutdown request, halt status and the statistics.
// A result passes through the input register and then the result register
// before it is presented on m_axis; one request per cycle is sustained while
// m_axis_tready stays high, set by the state update between the input
// register and the result register.
// The input register keeps taking a new request while a finished result waits
// in the result register; when m_axis_tready stays low, both registers fill
// and s_axis_tready drops until the result is taken. Nothing is lost.
// Reset clears the monitor state, empties both registers and loads
// fail_limit = 3 and real_poweroff = 0. Configuration writes (cfg_we_i,
// cfg_idx_i, cfg_wdata_i) take effect at once; the user must issue them
// while idle, as the block does not enforce it. Once halted, every later
// request answers with event kind none and the frozen statistics.
module heartbeat_link_monitor (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [7:0]   cfg_wdata_i,
  // event requests
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // now_us[47:0], probe_number[63:48],
                                       // send_ok[64], action_ok[65], zero pad
  input  logic [2:0]   s_axis_tuser,   // command[2:0]
  // results
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata,   // reply_lat[31:0], fail_streak[39:32],
                                       // shutdown_request[40], halted[41],
                                       // exit_status[42], total_count[74:43],
                                       // ok_count[106:75], failed_count[138:107],
                                       // latency_total[186:139],
                                       // latency_low[218:187],
                                       // latency_high[250:219], zero pad
  output logic [1:0]   m_axis_tuser    // event_kind[1:0]
);

  hlm_pkg::cfg_t    cfg_q;
  hlm_pkg::item_t   in_item_q, in_item;
  hlm_pkg::result_t res, out_res_q;
  logic             in_valid_q, out_valid_q;
  logic             out_free, fire, s_accept;

  // Handshake: a request is processed when the result register can take it
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Unpack the request
  always_comb begin
    in_item.command      = s_axis_tuser;
    in_item.now_us       = s_axis_tdata[47:0];
    in_item.probe_number = s_axis_tdata[63:48];
    in_item.send_ok      = s_axis_tdata[64];
    in_item.action_ok    = s_axis_tdata[65];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fail_limit    <= hlm_pkg::FAIL_LIMIT_RST;
      cfg_q.real_poweroff <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hlm_pkg::CFG_FAIL_LIMIT:    cfg_q.fail_limit    <= cfg_wdata_i;
        hlm_pkg::CFG_REAL_POWEROFF: cfg_q.real_poweroff <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q <= in_item;
    end
  end

  hlm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res;
    end
  end

  // Pack the result
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.event_kind;
  assign m_axis_tdata  = {5'd0,
                          out_res_q.latency_high,
                          out_res_q.latency_low,
                          out_res_q.latency_total,
                          out_res_q.failed_count,
                          out_res_q.ok_count,
                          out_res_q.total_count,
                          out_res_q.exit_status,
                          out_res_q.halted,
                          out_res_q.shutdown_request,
                          out_res_q.fail_streak,
                          out_res_q.reply_lat};

endmodule

FILE: design/hlm_core.sv
// Monitor state, statistics and next-result logic for one request per cycle while fire_i is high.
module hlm_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  hlm_pkg::item_t    item_i,
  input  hlm_pkg::cfg_t     cfg_i,
  output hlm_pkg::result_t  res_o
);

  typedef struct packed {
    logic        awaiting_reply;
    logic [15:0] pending_number;
    logic [47:0] sent_time;
    logic [7:0]  streak;
    logic        awaiting_report;
    logic        stopped;
    logic        stop_code;
    logic [31:0] resolved;
    logic [31:0] success;
    logic [31:0] failure;
    logic [47:0] lat_sum;
    logic [31:0] lat_min;
    logic [31:0] lat_max;
    logic        has_sample;
  } state_t;

  state_t st_q, st_d;

  // reset image: everything clear, latency extremes all ones
  localparam state_t ST_RST = '{lat_min: '1, lat_max: '1, default: '0};

  logic [47:0] diff;
  logic [31:0] lat;
  logic [48:0] sum_ext;
  logic [47:0] sum_sat;
  logic [7:0]  streak_inc;

  hlm_pkg::ev_e kind;
  logic [31:0]  lat_out;
  logic         req;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == '1) ? v : v + 32'd1;
  endfunction

  // Latency datapath: skew clamp, 32-bit saturation, saturating sum
  always_comb begin
    diff    = (item_i.now_us >= st_q.sent_time) ? item_i.now_us - st_q.sent_time : '0;
    lat     = (|diff[47:32]) ? '1 : diff[31:0];
    sum_ext = {1'b0, st_q.lat_sum} + {1'b0, diff};
    sum_sat = sum_ext[48] ? '1 : sum_ext[47:0];
    streak_inc = (st_q.streak == '1) ? st_q.streak : st_q.streak + 8'd1;
  end

  // Event handling
  always_comb begin
    st_d    = st_q;
    kind    = hlm_pkg::EV_NONE;
    lat_out = '0;
    req     = 1'b0;
    if (fire_i && !st_q.stopped) begin
      if (st_q.awaiting_report) begin
        if (item_i.command == hlm_pkg::CMD_REPORT) begin
          st_d.awaiting_report = 1'b0;
          if (item_i.action_ok) begin
            st_d.stopped   = 1'b1;
            st_d.stop_code = 1'b0;
          end
        end
      end else begin
        case (hlm_pkg::cmd_e'(item_i.command))
          hlm_pkg::CMD_TICK: begin
            if (!st_q.awaiting_reply) begin
              if (!item_i.send_ok) begin
                st_d.stopped   = 1'b1;
                st_d.stop_code = 1'b1;
              end else begin
                st_d.awaiting_reply = 1'b1;
                st_d.pending_number = item_i.probe_number;
                st_d.sent_time      = item_i.now_us;
                kind                = hlm_pkg::EV_SENT;
              end
            end
          end
          hlm_pkg::CMD_REPLY: begin
            if (st_q.awaiting_reply && item_i.probe_number == st_q.pending_number) begin
              st_d.awaiting_reply = 1'b0;
              st_d.streak         = '0;
              st_d.resolved       = sat_inc32(st_q.resolved);
              st_d.success        = sat_inc32(st_q.success);
              st_d.lat_sum        = sum_sat;
              if (!st_q.has_sample || lat < st_q.lat_min) st_d.lat_min = lat;
              if (!st_q.has_sample || lat > st_q.lat_max) st_d.lat_max = lat;
              st_d.has_sample     = 1'b1;
              kind                = hlm_pkg::EV_REPLY;
              lat_out             = lat;
            end
          end
          hlm_pkg::CMD_DEADLINE: begin
            if (st_q.awaiting_reply) begin
              st_d.awaiting_reply = 1'b0;
              st_d.streak         = streak_inc;
              st_d.resolved       = sat_inc32(st_q.resolved);
              st_d.failure        = sat_inc32(st_q.failure);
              kind                = hlm_pkg::EV_TIMEOUT;
              // threshold reached: dry run stops, real run asks for shutdown
              if (streak_inc >= cfg_i.fail_limit) begin
                if (!cfg_i.real_poweroff) begin
                  st_d.stopped   = 1'b1;
                  st_d.stop_code = 1'b0;
                end else begin
                  st_d.awaiting_report = 1'b1;
                  req                  = 1'b1;
                end
              end
            end
          end
          hlm_pkg::CMD_RX_ERROR: begin
            st_d.awaiting_reply = 1'b0;
            st_d.stopped        = 1'b1;
            st_d.stop_code      = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Result fields come from the updated state
  always_comb begin
    res_o.event_kind       = kind;
    res_o.reply_lat        = lat_out;
    res_o.fail_streak      = st_d.streak;
    res_o.shutdown_request = req;
    res_o.halted           = st_d.stopped;
    res_o.exit_status      = st_d.stopped & st_d.stop_code;
    res_o.total_count      = st_d.resolved;
    res_o.ok_count         = st_d.success;
    res_o.failed_count     = st_d.failure;
    res_o.latency_total    = st_d.lat_sum;
    res_o.latency_low      = st_d.has_sample ? st_d.lat_min : '1;
    res_o.latency_high     = st_d.has_sample ? st_d.lat_max : '1;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_RST;
    end else begin
      st_q <= st_d;
    end
  end

  // Checks
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.stopped |=> st_q.stopped) else $error("halted flag cleared");

  a_halt_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.stopped |=> $stable(st_q.resolved) && $stable(st_q.lat_sum))
    else $error("statistics changed after halt");

  a_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.resolved != '1) |->
      ({1'b0, st_q.resolved} == {1'b0, st_q.success} + {1'b0, st_q.failure}))
    else $error("resolved count differs from ok plus failed");

  a_report_no_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.awaiting_report |-> !st_q.awaiting_reply)
    else $error("probe outstanding while waiting for shutdown report");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.has_sample |-> (st_q.lat_min <= st_q.lat_max))
    else $error("latency minimum above maximum");

endmodule
